/* rtl/core/psgrg_pkg.sv */
`default_nettype none

package psgrg_pkg;

  localparam int SID_W      = 6;
  localparam int CAP_W      = 62;
  localparam int NOW_W      = 53;
  localparam int GAP_W      = 32;
  localparam int EPOCH_W    = 32;
  localparam int TIME_W     = 54;

  localparam int SID_LSB    = 0;
  localparam int CAP_LSB    = SID_LSB + SID_W;
  localparam int NOW_LSB    = CAP_LSB + CAP_W;
  localparam int GAP_LSB    = NOW_LSB + NOW_W;
  localparam int IN_FIELD_W = GAP_LSB + GAP_W;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 8;

  localparam int MAX_STREAMS = 2 ** SID_W;

  localparam logic [EPOCH_W-1:0] EPOCH_RESET_DEFAULT = 32'd1000000;
  localparam int NS_PER_US   = 1000;

  localparam int DIV_N_W     = CAP_W;
  localparam int DIV_D_W     = GAP_W;
  localparam int RADIX_BITS  = 2;

  typedef struct packed {
    logic                warned;
    logic                stamped;
    logic [TIME_W-1:0]   grid;
    logic [GAP_W-1:0]    gap;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    RES_POLICY,
    RES_BYPASS,
    RES_DROP,
    RES_PASS
  } res_t;

  typedef enum logic [1:0] {
    WR_POLICY,
    WR_FLAGS,
    WR_ADVANCE
  } wr_kind_t;

  typedef struct packed {
    logic     load_in;
    logic     clr_we;
    logic     rd;
    logic     div_t;
    logic     div_r;
    logic     take_t_now;
    logic     take_t_div;
    logic     wr;
    wr_kind_t wr_kind;
    logic     out_load;
    res_t     res;
  } cmd_t;

  typedef struct packed {
    logic policy;
    logic in_rng;
    logic gap_zero;
    logic stamped;
    logic early_drop;
    logic div_done;
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/per_stream_grid_rate_gate.sv */
`default_nettype none

// channel  signals                         fields (tdata from bit 0 up)
// in       in_tvalid/in_tready             tuser: operation
//                                          tdata: stream_id, capture_time_ns,
//                                                 now_us, new_gap_us, pad
// out      out_tvalid/out_tready           tdata: passed, mixed_clock_warning, pad
// cfg      cfg_valid/cfg_ready             cfg_data: epoch_reset_us
//
// After reset the stream table's min(STREAM_COUNT, 64) entries are swept to zero,
// one entry a cycle; in_tready stays low meanwhile.
// Policy and uncapped words do not use the divider. A gated message uses the shared
// radix-4 divider once for ns to us if it is stamped, and once for the grid remainder
// unless it is dropped.
// One word in flight; the next is taken while a result waits in the output register.

module per_stream_grid_rate_gate #(
  parameter int STREAM_COUNT = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // stream_id, capture_time_ns, now_us, new_gap_us, zero pad
  input  wire logic [psgrg_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  wire logic [psgrg_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // passed, mixed_clock_warning, zero pad
  output logic      [psgrg_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [psgrg_pkg::EPOCH_W-1:0]    cfg_data
);
  import psgrg_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  psgrg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  psgrg_dp #(
    .STREAM_COUNT (STREAM_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

/* rtl/core/psgrg_ram.sv */
`default_nettype none

module psgrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/psgrg_div.sv */
`default_nettype none

module psgrg_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [psgrg_pkg::DIV_N_W-1:0] dividend,
  input  wire logic [psgrg_pkg::DIV_D_W-1:0] divisor,
  output logic                              busy,
  output logic                              done,
  output logic      [psgrg_pkg::DIV_N_W-1:0] quotient,
  output logic      [psgrg_pkg::DIV_D_W-1:0] remainder
);
  import psgrg_pkg::*;

  localparam int STEPS = DIV_N_W / RADIX_BITS;
  localparam int CNT_W = $clog2(STEPS);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_N_W-1:0] quo_nxt;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] rem_nxt;
  logic [DIV_D_W-1:0] dvs_r;

  // radix-4 restoring step: two quotient bits per cycle
  always_comb begin
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W-1:0] r;
    logic [DIV_N_W-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial = {r, q[DIV_N_W-1]};
      q     = {q[DIV_N_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        r    = DIV_D_W'(trial - {1'b0, dvs_r});
        q[0] = 1'b1;
      end else begin
        r = trial[DIV_D_W-1:0];
      end
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not go busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a run");
`endif

endmodule

`default_nettype wire

/* rtl/core/psgrg_dp.sv */
`default_nettype none

module psgrg_dp #(
  parameter int STREAM_COUNT = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [psgrg_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [psgrg_pkg::IN_USER_W-1:0] in_tuser,
  input  wire logic                            cfg_valid,
  input  wire logic [psgrg_pkg::EPOCH_W-1:0]   cfg_data,
  input  wire psgrg_pkg::cmd_t                 cmd,
  output psgrg_pkg::status_t                   st,
  output logic      [psgrg_pkg::OUT_DATA_W-1:0] out_tdata
);
  import psgrg_pkg::*;

  localparam int DEPTH = (STREAM_COUNT < MAX_STREAMS) ? STREAM_COUNT : MAX_STREAMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               op_r;
  logic [SID_W-1:0]   sid_r;
  logic [CAP_W-1:0]   cap_r;
  logic [NOW_W-1:0]   now_r;
  logic [GAP_W-1:0]   ngap_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [TIME_W-1:0]  t_r;
  logic [TIME_W-1:0]  slot_r;
  logic [TIME_W-1:0]  slot_nxt;
  logic [AW-1:0]      clr_cnt_r;
  logic               pass_r;
  logic               warn_r;

  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      waddr;
  logic               ram_we;
  entry_t             ent;
  entry_t             wr_ent;

  logic               in_rng;
  logic               stamped_now;
  logic               unseeded;
  logic               warn_now;
  logic               keep;
  logic               early;
  logic               drop;
  logic [TIME_W-1:0]  gap_ext;
  logic [TIME_W-1:0]  base;
  logic [TIME_W-1:0]  new_grid;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIV_N_W-1:0] div_quo;
  logic [DIV_D_W-1:0] div_rem;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_tuser[0];
      sid_r  <= in_tdata[SID_LSB +: SID_W];
      cap_r  <= in_tdata[CAP_LSB +: CAP_W];
      now_r  <= in_tdata[NOW_LSB +: NOW_W];
      ngap_r <= in_tdata[GAP_LSB +: GAP_W];
    end
    if (cmd.take_t_now) begin
      t_r <= TIME_W'(now_r);
    end else if (cmd.take_t_div) begin
      t_r <= div_quo[TIME_W-1:0];
    end
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r   <= EPOCH_RESET_DEFAULT;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_valid) begin
        epoch_r <= cfg_data;
      end
      if (cmd.clr_we) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  assign in_rng      = int'(sid_r) < STREAM_COUNT;
  assign addr        = sid_r[AW-1:0];
  assign ent         = entry_t'(rd_data);
  assign stamped_now = cap_r != '0;
  assign unseeded    = ent.grid == '0;
  assign warn_now    = !unseeded && (stamped_now != ent.stamped) && !ent.warned;
  assign keep        = (ngap_r != '0) && (ngap_r == ent.gap);
  assign gap_ext     = TIME_W'(ent.gap);
  assign slot_nxt    = (ent.grid >= gap_ext) ? ent.grid - gap_ext : '0;
  assign early       = t_r < ent.grid;
  assign drop        = (t_r >= slot_r) || ((slot_r - t_r) <= TIME_W'(epoch_r));
  assign base        = early ? '0 : ent.grid;
  // grid + gap * (1 + (t - grid) / gap) == t - (t - grid) % gap + gap
  assign new_grid    = t_r - TIME_W'(div_rem) + gap_ext;

  always_comb begin
    wr_ent = ent;
    case (cmd.wr_kind)
      WR_POLICY: begin
        if (!keep) begin
          wr_ent.warned  = 1'b0;
          wr_ent.stamped = 1'b0;
          wr_ent.grid    = '0;
        end
        wr_ent.gap = ngap_r;
      end
      WR_FLAGS: begin
        wr_ent.stamped = unseeded ? stamped_now : ent.stamped;
        wr_ent.warned  = ent.warned | warn_now;
      end
      WR_ADVANCE: begin
        wr_ent.stamped = unseeded ? stamped_now : ent.stamped;
        wr_ent.warned  = ent.warned | warn_now;
        wr_ent.grid    = new_grid;
      end
      default: begin
        wr_ent = ent;
      end
    endcase
  end

  assign ram_we  = cmd.clr_we | cmd.wr;
  assign waddr   = cmd.clr_we ? clr_cnt_r : addr;
  assign wr_data = cmd.clr_we ? '0 : ENTRY_W'(wr_ent);

  psgrg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wr_data),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign div_start = cmd.div_t | cmd.div_r;
  assign div_n     = cmd.div_t ? cap_r : DIV_N_W'(t_r - base);
  assign div_d     = cmd.div_t ? DIV_D_W'(NS_PER_US) : ent.gap;

  psgrg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res)
        RES_POLICY: begin
          pass_r <= 1'b0;
          warn_r <= 1'b0;
        end
        RES_BYPASS: begin
          pass_r <= 1'b1;
          warn_r <= 1'b0;
        end
        RES_DROP: begin
          pass_r <= 1'b0;
          warn_r <= warn_now;
        end
        RES_PASS: begin
          pass_r <= 1'b1;
          warn_r <= warn_now;
        end
        default: begin
          pass_r <= 1'b0;
          warn_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_tdata = {{(OUT_DATA_W - 2){1'b0}}, warn_r, pass_r};

  assign st.policy     = op_r;
  assign st.in_rng     = in_rng;
  assign st.gap_zero   = ent.gap == '0;
  assign st.stamped    = stamped_now;
  assign st.early_drop = early && drop;
  assign st.div_done   = div_done;
  assign st.clr_last   = clr_cnt_r == AW'(DEPTH - 1);

`ifndef ASSERT_OFF
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divide issued while divider busy");
  a_wr_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> !cmd.rd && !cmd.clr_we)
    else $error("table write collides with read or clear");
  a_ovf_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr && cmd.wr_kind == WR_ADVANCE) |-> new_grid > t_r)
    else $error("advanced grid not past message time");
`endif

endmodule

`default_nettype wire

/* rtl/core/psgrg_ctrl.sv */
`default_nettype none

module psgrg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire psgrg_pkg::status_t st,
  output psgrg_pkg::cmd_t         cmd
);
  import psgrg_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WAIT_T,
    S_CHECK,
    S_WAIT_R,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  res_t   res_r;
  res_t   res_nxt;
  logic   in_rdy_r;
  logic   in_rdy_nxt;
  logic   out_vld_r;
  logic   out_vld_nxt;

  always_comb begin
    state_nxt   = state_r;
    res_nxt     = res_r;
    in_rdy_nxt  = in_rdy_r;
    out_vld_nxt = out_vld_r & ~out_tready;
    cmd         = '0;
    cmd.res     = res_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (st.clr_last) begin
          state_nxt  = S_IDLE;
          in_rdy_nxt = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_rdy_r) begin
          cmd.load_in = 1'b1;
          in_rdy_nxt  = 1'b0;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (st.policy) begin
          if (st.in_rng) begin
            cmd.wr      = 1'b1;
            cmd.wr_kind = WR_POLICY;
          end
          res_nxt   = RES_POLICY;
          state_nxt = S_DONE;
        end else if (!st.in_rng || st.gap_zero) begin
          res_nxt   = RES_BYPASS;
          state_nxt = S_DONE;
        end else if (st.stamped) begin
          cmd.div_t = 1'b1;
          state_nxt = S_WAIT_T;
        end else begin
          cmd.take_t_now = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_WAIT_T: begin
        if (st.div_done) begin
          cmd.take_t_div = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.early_drop) begin
          cmd.wr      = 1'b1;
          cmd.wr_kind = WR_FLAGS;
          res_nxt     = RES_DROP;
          state_nxt   = S_DONE;
        end else begin
          cmd.div_r = 1'b1;
          state_nxt = S_WAIT_R;
        end
      end
      S_WAIT_R: begin
        if (st.div_done) begin
          cmd.wr      = 1'b1;
          cmd.wr_kind = WR_ADVANCE;
          res_nxt     = RES_PASS;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          out_vld_nxt  = 1'b1;
          in_rdy_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt  = S_IDLE;
        in_rdy_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      res_r     <= RES_POLICY;
      in_rdy_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_r     <= res_nxt;
      in_rdy_r  <= in_rdy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = in_rdy_r;
  assign out_tvalid = out_vld_r;

`ifndef ASSERT_OFF
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_rdy_r) |=> state_r == S_READ)
    else $error("accepted word not followed by table read");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_rdy_r |-> state_r == S_IDLE)
    else $error("ready outside idle");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_vld_r && !out_tready) |=> state_r == S_DONE)
    else $error("result overwrote a pending word");
`endif

endmodule

`default_nettype wire

/* test/per_stream_grid_rate_gate_tb.sv */
`timescale 1ns / 100ps

module per_stream_grid_rate_gate_tb;
  import psgrg_pkg::*;

  localparam bit OP_MESSAGE = 1'b0;
  localparam bit OP_POLICY  = 1'b1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_STALL  = 400;
  localparam int DRAIN_WAIT  = 200;
  localparam bit [63:0] NS_PER_US_64 = 64'd1000;
  localparam bit [63:0] T_MASK = (64'd1 << 52) - 64'd1;

  typedef struct {
    bit              op;
    bit [SID_W-1:0]  sid;
    bit [CAP_W-1:0]  cap;
    bit [NOW_W-1:0]  now;
    bit [GAP_W-1:0]  gap;
  } gate_word_t;

  typedef struct {
    bit [SID_W-1:0] sid;
    bit             passed;
    bit             warn;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [EPOCH_W-1:0]    cfg_data = '0;

  per_stream_grid_rate_gate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // rate gate state mirror
  bit [GAP_W-1:0]   gap_tbl [MAX_STREAMS];
  bit [TIME_W-1:0]  grid_tbl [MAX_STREAMS];
  bit               stamped_tbl [MAX_STREAMS];
  bit               warned_tbl [MAX_STREAMS];
  bit [EPOCH_W-1:0] epoch_cfg = EPOCH_RESET_DEFAULT;

  // stimulus shaping per stream
  bit [GAP_W-1:0] gen_gap [MAX_STREAMS];
  bit [63:0]      gen_t [MAX_STREAMS];
  bit             gen_stamped [MAX_STREAMS];
  bit [SID_W-1:0] hot_sid [8];

  gate_word_t pending_words [$];
  verdict_t   verdicts_due [$];
  gate_word_t word_on_bus;

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  sender_hold = 1'b0;
  bit  stall_req = 1'b0;
  int  stall_left = 0;
  int  errors = 0;
  int  words_in = 0;
  int  results_seen = 0;
  int  passes_seen = 0;
  int  warns_seen = 0;
  int  reseeds = 0;
  int  epoch_writes = 0;
  int  cycles = 0;

  function automatic verdict_t gate_word(gate_word_t w);
    verdict_t  v;
    bit        stamped;
    bit [63:0] t, g, slot, gp;
    v = '{sid: w.sid, passed: 1'b0, warn: 1'b0};
    if (w.op == OP_POLICY) begin
      if (!(w.gap != 0 && w.gap == gap_tbl[w.sid])) begin
        grid_tbl[w.sid] = '0;
        stamped_tbl[w.sid] = 1'b0;
        warned_tbl[w.sid] = 1'b0;
      end
      gap_tbl[w.sid] = w.gap;
    end else if (gap_tbl[w.sid] == 0) begin
      v.passed = 1'b1;
    end else begin
      gp = 64'(gap_tbl[w.sid]);
      stamped = (w.cap != 0);
      t = stamped ? 64'(w.cap) / NS_PER_US_64 : 64'(w.now);
      g = 64'(grid_tbl[w.sid]);
      if (g == 0) begin
        stamped_tbl[w.sid] = stamped;
      end else if (stamped != stamped_tbl[w.sid] && !warned_tbl[w.sid]) begin
        warned_tbl[w.sid] = 1'b1;
        v.warn = 1'b1;
      end
      v.passed = 1'b1;
      if (t < g) begin
        slot = (g >= gp) ? g - gp : 64'd0;
        if (t >= slot || slot - t <= 64'(epoch_cfg)) begin
          v.passed = 1'b0;
        end else begin
          g = 64'd0;
          reseeds++;
        end
      end
      if (v.passed) begin
        g = g + gp * (1 + (t - g) / gp);
        grid_tbl[w.sid] = g[TIME_W-1:0];
      end
    end
    return v;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_message(bit [SID_W-1:0] sid, bit [CAP_W-1:0] cap, bit [NOW_W-1:0] now);
    pending_words.push_back('{op: OP_MESSAGE, sid: sid, cap: cap, now: now, gap: $urandom});
  endtask

  task automatic push_policy(bit [SID_W-1:0] sid, bit [GAP_W-1:0] gap);
    pending_words.push_back('{op: OP_POLICY, sid: sid, cap: rand64(), now: rand64(), gap: gap});
  endtask

  function automatic gate_word_t make_word();
    gate_word_t w;
    int unsigned r;
    bit [63:0] t, d, gp;
    w.op = OP_MESSAGE;
    w.sid = ($urandom_range(99) < 70) ? hot_sid[$urandom_range(7)] : SID_W'($urandom);
    w.cap = rand64();
    w.now = rand64();
    w.gap = $urandom;
    r = $urandom_range(99);
    if (r < 8) begin
      w.op = $urandom_range(1);
      if (w.op == OP_POLICY) gen_gap[w.sid] = w.gap;
      return w;
    end
    if (r < 18) begin
      w.op = OP_POLICY;
      r = $urandom_range(99);
      if (r < 30) w.gap = gen_gap[w.sid];
      else if (r < 40) w.gap = '0;
      else if (r < 50) w.gap = $urandom;
      else w.gap = $urandom_range(20000, 1);
      gen_gap[w.sid] = w.gap;
      return w;
    end
    gp = (gen_gap[w.sid] == 0) ? 64'd1000 : 64'(gen_gap[w.sid]);
    t = gen_t[w.sid];
    r = $urandom_range(99);
    if (r < 55) begin
      t = t + rand64() % (2 * gp + 1);
    end else if (r < 75) begin
      d = rand64() % (gp + 1);
      t = (d > t) ? 64'd0 : t - d;
    end else if (r < 85) begin
      d = 64'(epoch_cfg) + 1 + rand64() % (2 * gp + 1);
      t = (d > t) ? 64'd0 : t - d;
    end else if (r < 90) begin
      d = 64'(epoch_cfg) + gp - $urandom_range(3);
      t = (d > t) ? 64'd0 : t - d;
    end else if (r < 95) begin
      t = t + (rand64() & 64'hFF_FFFF_FFFF);
    end else begin
      t = rand64();
    end
    t = t & T_MASK;
    gen_t[w.sid] = t;
    if ($urandom_range(99) < 5) gen_stamped[w.sid] = ~gen_stamped[w.sid];
    if (gen_stamped[w.sid]) begin
      w.cap = CAP_W'(t * NS_PER_US_64 + $urandom_range(999));
    end else begin
      w.cap = '0;
      w.now = NOW_W'(t);
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || verdicts_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_epoch(bit [EPOCH_W-1:0] value);
    wait_drained();
    repeat (20) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    epoch_cfg = value;
    cfg_valid <= 1'b0;
    epoch_writes++;
    @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    logic [IN_DATA_W-1:0] bus;
    bit                   offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdicts_due.push_back(gate_word(word_on_bus));
        words_in++;
      end
      if (!in_tvalid || in_tready) begin
        offer = pending_words.size() != 0 && !sender_hold && $urandom_range(99) >= idle_pct;
        if (offer) begin
          word_on_bus = pending_words.pop_front();
          bus = '0;
          bus[SID_LSB +: SID_W] = word_on_bus.sid;
          bus[CAP_LSB +: CAP_W] = word_on_bus.cap;
          bus[NOW_LSB +: NOW_W] = word_on_bus.now;
          bus[GAP_LSB +: GAP_W] = word_on_bus.gap;
          in_tvalid <= 1'b1;
          in_tdata <= bus;
          in_tuser <= IN_USER_W'(word_on_bus.op);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, got %h", $time, out_tdata);
      end else begin
        want = verdicts_due.pop_front();
        if (out_tdata[0] !== want.passed) begin
          errors++;
          $display("%0t: stream %0d passed: expected %0b, got %0b",
                   $time, want.sid, want.passed, out_tdata[0]);
        end
        if (out_tdata[1] !== want.warn) begin
          errors++;
          $display("%0t: stream %0d mixed clock warning: expected %0b, got %0b",
                   $time, want.sid, want.warn, out_tdata[1]);
        end
        results_seen++;
        passes_seen += want.passed;
        warns_seen += want.warn;
      end
    end
    if (stall_req && stall_left == 0) begin
      stall_left = LONG_STALL;
      stall_req = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, verdicts_due.size());
      $display("[per_stream_grid_rate_gate] ERROR");
      $finish;
    end
  end

  initial begin
    int        phase_epoch [4];
    int        phase_idle [4];
    int        phase_stall [4];
    int        phase_words [4];
    bit [63:0] big;
    phase_epoch = '{0, 32'hFFFF_FFFF, 5000, 0};
    phase_idle  = '{0, 78, 0, 11};
    phase_stall = '{0, 0, 78, 11};
    phase_words = '{300, 300, 400, 400};
    phase_epoch[3] = $urandom_range(200000, 2000);
    for (int i = 0; i < MAX_STREAMS; i++) begin
      gen_t[i] = rand64() & 64'hFFFF_FFFF_FFFF;
      gen_stamped[i] = $urandom_range(1);
    end
    for (int i = 0; i < 8; i++) hot_sid[i] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // gate behavior at the reset epoch
    push_message(5, 0, 100);
    push_policy(5, 1000);
    push_message(5, 0, 5000);
    push_message(5, 0, 5500);
    push_message(5, 0, 6000);
    push_message(5, 7000999, 0);
    push_message(5, 8500000, 0);
    push_policy(9, 10);
    push_message(9, 0, 5000000);
    push_message(9, 0, 4000000);
    push_message(9, 0, 3999999);
    push_policy(9, 10);
    push_message(9, 0, 3999995);
    push_policy(9, 20);
    push_message(9, 0, 3999995);
    push_policy(63, 32'hFFFF_FFFF);
    big = (64'd1 << CAP_W) - 1;
    push_message(63, CAP_W'(big), 0);
    big = (64'd1 << NOW_W) - 1;
    push_message(63, 0, NOW_W'(big));
    push_policy(0, 1);
    push_message(0, 1, 0);
    push_message(0, 999, 0);
    push_policy(0, 0);
    push_message(0, 999, 0);
    push_policy(0, 0);
    for (int i = 0; i < pending_words.size(); i++)
      if (pending_words[i].op == OP_POLICY) gen_gap[pending_words[i].sid] = pending_words[i].gap;

    for (int p = 0; p < 4; p++) begin
      write_epoch(phase_epoch[p]);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 1) begin
        repeat (phase_words[p] / 2) pending_words.push_back(make_word());
        while (pending_words.size() != 0) @(negedge clk);
        sender_hold = 1'b1;
        while (in_tvalid || verdicts_due.size() != 0) @(negedge clk);
        sender_hold = 1'b0;
        repeat (phase_words[p] / 2) pending_words.push_back(make_word());
      end else begin
        repeat (phase_words[p]) pending_words.push_back(make_word());
        if (p == 0) stall_req = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("covered %0d words over %0d epoch settings with idle and stall phases",
             words_in, epoch_writes + 1);
    $display("results %0d: %0d passed, %0d dropped or policy, %0d clock mix warnings, %0d re-seeds",
             results_seen, passes_seen, results_seen - passes_seen, warns_seen, reseeds);
    if (errors == 0) begin
      $display("[per_stream_grid_rate_gate] OK");
    end else begin
      $display("[per_stream_grid_rate_gate] ERROR");
    end
    $finish;
  end

endmodule

/* per_stream_grid_rate_gate.f */
rtl/core/psgrg_pkg.sv
rtl/core/psgrg_ram.sv
rtl/core/psgrg_div.sv
rtl/core/psgrg_dp.sv
rtl/core/psgrg_ctrl.sv
rtl/core/per_stream_grid_rate_gate.sv
test/per_stream_grid_rate_gate_tb.sv
